// File: rtl/button_click_event_tracker_assert.svh
// assertion macros shared by the button tracker checker
// no dependencies; expects a signal named clk in the using scope
`ifndef BUTTON_CLICK_EVENT_TRACKER_ASSERT_SVH
`define BUTTON_CLICK_EVENT_TRACKER_ASSERT_SVH

// consequent must hold in the next cycle
`define BCT_ASSERT_NEXT(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("button tracker check failed: next-cycle property");

// consequent must hold in the same cycle
`define BCT_ASSERT_SAME(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("button tracker check failed: same-cycle property");

`endif

// File: rtl/bct_pkg.sv
// types and constants for the button click event tracker
// no dependencies; used by bct_core, button_click_event_tracker and bct_checker
package bct_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned FLAG_W   = 11;
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 8;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned IDX_W    = 2;

  localparam logic [THR_W-1:0] DOUBLE_CLICK_RST = 16'd250;
  localparam logic [THR_W-1:0] LONG_PRESS_RST   = 16'd500;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_LEVEL = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    Q_IS_PRESSED       = 4'd0,
    Q_PRESSED_FOR      = 4'd1,
    Q_RELEASED_FOR     = 4'd2,
    Q_WAS_PRESSED      = 4'd3,
    Q_WAS_RELEASED     = 4'd4,
    Q_WAS_PRESSED_FOR  = 4'd5,
    Q_WAS_RELEASED_FOR = 4'd6,
    Q_WAS_LONG         = 4'd7,
    Q_WAS_DOUBLE       = 4'd8,
    Q_IS_LONG          = 4'd9,
    Q_IS_RELEASED      = 4'd10
  } query_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DOUBLE_CLICK = 2'd0,
    REG_LONG_PRESS   = 2'd1
  } reg_idx_t;

  // event flag bit positions
  localparam int unsigned FL_ACTIVE  = 0;
  localparam int unsigned FL_PRESS   = 1;
  localparam int unsigned FL_RELEASE = 2;
  localparam int unsigned FL_DOUBLE  = 3;
  localparam int unsigned FL_LONG    = 4;
  localparam int unsigned FL_PRESS_RD = 5;
  localparam int unsigned FL_REL_RD  = 6;
  localparam int unsigned FL_PFOR_RD = 7;
  localparam int unsigned FL_RFOR_RD = 8;
  localparam int unsigned FL_DBL_RD  = 9;
  localparam int unsigned FL_LONG_RD = 10;

  typedef struct packed {
    logic [1:0]        kind;
    logic              level;
    logic [3:0]        query;
    logic [TIME_W-1:0] duration_ms;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0] double_click_ms;
    logic [THR_W-1:0] long_press_ms;
  } thr_t;

endpackage

// File: rtl/bct_core.sv
// button state registers and the per-request update and query logic
// depends on bct_pkg
module bct_core import bct_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  input  thr_t  thr,
  output logic  answer,
  output logic  pressed
);

  logic [TIME_W-1:0] time_now, time_now_next;
  logic [TIME_W-1:0] last_change_time, last_change_time_next;
  logic [TIME_W-1:0] last_press_span, last_press_span_next;
  logic [TIME_W-1:0] last_release_span, last_release_span_next;
  logic [FLAG_W-1:0] event_flags, event_flags_next;

  logic [TIME_W-1:0] elapsed;
  logic              active;
  logic              held_ms;
  logic              idle_ms;
  logic              held_long;

  assign elapsed   = time_now - last_change_time;
  assign active    = event_flags[FL_ACTIVE];
  assign held_ms   = active && (elapsed > item.duration_ms);
  assign idle_ms   = !active && (elapsed > item.duration_ms);
  assign held_long = active && (elapsed > {{(TIME_W-THR_W){1'b0}}, thr.long_press_ms});

  always_comb begin
    time_now_next          = time_now;
    last_change_time_next  = last_change_time;
    last_press_span_next   = last_press_span;
    last_release_span_next = last_release_span;
    event_flags_next       = event_flags;
    answer                 = 1'b0;
    case (item.kind)
      KIND_TICK: begin
        time_now_next = time_now + 1'b1;
      end
      KIND_LEVEL: begin
        last_change_time_next = time_now;
        if (item.level) begin
          event_flags_next[FL_PRESS]   = 1'b1;
          event_flags_next[FL_ACTIVE]  = 1'b1;
          event_flags_next[FL_LONG_RD] = 1'b0;
          event_flags_next[FL_PFOR_RD] = 1'b0;
          last_press_span_next   = '0;
          last_release_span_next = elapsed;
          if (elapsed <= {{(TIME_W-THR_W){1'b0}}, thr.double_click_ms}) begin
            if (!event_flags[FL_DBL_RD]) begin
              event_flags_next[FL_DOUBLE] = 1'b1;
              event_flags_next[FL_DBL_RD] = 1'b1;
            end
          end else begin
            event_flags_next[FL_DBL_RD] = 1'b0;
          end
        end else begin
          event_flags_next[FL_RELEASE] = 1'b1;
          event_flags_next[FL_RFOR_RD] = 1'b0;
          event_flags_next[FL_ACTIVE]  = 1'b0;
          last_release_span_next = '0;
          last_press_span_next   = elapsed;
          if ((elapsed >= {{(TIME_W-THR_W){1'b0}}, thr.long_press_ms})
              && !event_flags[FL_LONG_RD]) begin
            event_flags_next[FL_LONG] = 1'b1;
          end
        end
      end
      KIND_QUERY: begin
        case (item.query)
          Q_IS_PRESSED:   answer = active;
          Q_PRESSED_FOR:  answer = held_ms;
          Q_RELEASED_FOR: answer = idle_ms;
          Q_WAS_PRESSED: begin
            answer = event_flags[FL_PRESS];
            event_flags_next[FL_PRESS] = 1'b0;
          end
          Q_WAS_RELEASED: begin
            answer = event_flags[FL_RELEASE];
            event_flags_next[FL_RELEASE] = 1'b0;
          end
          Q_WAS_PRESSED_FOR: begin
            if (!event_flags[FL_PFOR_RD]
                && (held_ms || (last_press_span > item.duration_ms))) begin
              answer = 1'b1;
              event_flags_next[FL_PFOR_RD] = 1'b1;
            end
          end
          Q_WAS_RELEASED_FOR: begin
            if (!event_flags[FL_RFOR_RD]
                && (idle_ms || (last_release_span > item.duration_ms))) begin
              answer = 1'b1;
              event_flags_next[FL_RFOR_RD] = 1'b1;
            end
          end
          Q_WAS_LONG: begin
            if (!event_flags[FL_LONG_RD] && (held_long || event_flags[FL_LONG])) begin
              answer = 1'b1;
              event_flags_next[FL_LONG]    = 1'b0;
              event_flags_next[FL_LONG_RD] = 1'b1;
            end
          end
          Q_WAS_DOUBLE: begin
            answer = event_flags[FL_DOUBLE];
            event_flags_next[FL_DOUBLE] = 1'b0;
          end
          Q_IS_LONG:     answer = held_long;
          Q_IS_RELEASED: answer = !active;
          default:       answer = 1'b0;
        endcase
      end
      default: begin
      end
    endcase
  end

  // queries never move the active bit, so the next value is the reported one
  assign pressed = event_flags_next[FL_ACTIVE];

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now          <= '0;
      last_change_time  <= '0;
      last_press_span   <= '0;
      last_release_span <= '0;
      event_flags       <= '0;
    end else if (step) begin
      time_now          <= time_now_next;
      last_change_time  <= last_change_time_next;
      last_press_span   <= last_press_span_next;
      last_release_span <= last_release_span_next;
      event_flags       <= event_flags_next;
    end
  end

endmodule

// File: rtl/button_click_event_tracker.sv
// button click event tracker top level: input register, config registers,
// result register around the update core
// depends on bct_pkg and bct_core
//
// usage
//   s_* channel carries one request per transfer: tick, level change or query
//   (kind in s_tuser). ticks and level changes give no result; every query
//   gives exactly one result on the m_* channel.
//   cfg_we/cfg_index/cfg_data write the double-click and long-press
//   thresholds (index 0 and 1); write only while no request is in flight.
// pipeline and throughput
//   a request is held in the input register, processed by one pass of
//   combinational logic in bct_core and, for a query, lands in the result
//   register, which drives m_tvalid and m_tdata. one request per cycle is
//   sustained while no query waits on a full result register, set by the
//   single update pass over the button state.
// reset
//   synchronous rst clears the clock, the spans, all event flags and both
//   pipeline valids, and reloads the thresholds with 250 ms and 500 ms.
// stall
//   while a result waits in the result register, ticks and level changes
//   still flow; a query waits in the input register, and s_tready drops
//   until the result register frees.
module button_click_event_tracker import bct_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // level [0], query [4:1], duration_ms [36:5]
  input  logic [S_USER_W-1:0] s_tuser,   // kind [1:0]
  // result channel
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // answer [0], pressed [1]
  // threshold write port
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [THR_W-1:0]    cfg_data
);

  // input register
  logic  in_valid;
  item_t in_item;

  // threshold registers
  thr_t thr;

  logic advance;
  logic out_free;
  logic is_query;
  logic core_answer;
  logic core_pressed;

  assign is_query = (in_item.kind == KIND_QUERY);
  assign out_free = !m_tvalid || m_tready;
  // only a query needs room in the result register
  assign advance  = in_valid && (!is_query || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind        <= s_tuser;
      in_item.level       <= s_tdata[0];
      in_item.query       <= s_tdata[4:1];
      in_item.duration_ms <= s_tdata[36:5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.double_click_ms <= DOUBLE_CLICK_RST;
      thr.long_press_ms   <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOUBLE_CLICK: thr.double_click_ms <= cfg_data;
        REG_LONG_PRESS:   thr.long_press_ms   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bct_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (in_item),
    .thr     (thr),
    .answer  (core_answer),
    .pressed (core_pressed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_query) begin
      m_tdata <= {{(M_DATA_W-2){1'b0}}, core_pressed, core_answer};
    end
  end

endmodule

// File: rtl/bct_checker.sv
// port-level checker for the button click event tracker, with its bind
// depends on bct_pkg and button_click_event_tracker_assert.svh
`include "button_click_event_tracker_assert.svh"

module bct_checker import bct_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // a stalled result stays offered and unchanged
  `BCT_ASSERT_NEXT(a_out_hold, rst, m_tvalid && !m_tready, m_tvalid)
  `BCT_ASSERT_NEXT(a_out_stable, rst, m_tvalid && !m_tready, $stable(m_tdata))
  // reset empties both registers
  `BCT_ASSERT_NEXT(a_reset_empty, 1'b0, rst, !m_tvalid && s_tready)
  // with the result register empty nothing can hold back a request
  `BCT_ASSERT_SAME(a_ready_when_empty, rst, !m_tvalid, s_tready)

endmodule

bind button_click_event_tracker bct_checker u_bct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
